[hw/rtl/brute_force_shortest_tour_top_assert.svh]
// Assertion macros shared by the shortest-tour checker.
`ifndef BRUTE_FORCE_SHORTEST_TOUR_TOP_ASSERT_SVH
`define BRUTE_FORCE_SHORTEST_TOUR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define BFST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfst check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define BFST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfst check failed");

`endif

[hw/rtl/bfst_pkg.sv]
// Shared constants, command codes and control structs of the shortest-tour block.
package bfst_pkg;

    localparam int MAX_CITY_COUNT = 11;
    localparam int CITY_IDX_W     = $clog2(MAX_CITY_COUNT);
    localparam int CNT_W          = $clog2(MAX_CITY_COUNT + 1);
    localparam int COORD_W        = 20;
    localparam int SQ_W           = 2 * COORD_W + 1;
    localparam int LEG_W          = COORD_W + 1;
    localparam int SQRT_STEPS     = COORD_W + 1;
    localparam int STEP_W         = $clog2(SQRT_STEPS);
    localparam int SUM_W          = 25;
    localparam int LEN_W          = 24;
    localparam int LEG_ADDR_W     = 2 * CITY_IDX_W;
    localparam int OP_W           = 5;

    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] OP_ERR      = 5'd2;
    localparam logic [OP_W-1:0] OP_START    = 5'd3;
    localparam logic [OP_W-1:0] OP_PAIR_RD  = 5'd4;
    localparam logic [OP_W-1:0] OP_PAIR_DIF = 5'd5;
    localparam logic [OP_W-1:0] OP_PAIR_SQ  = 5'd6;
    localparam logic [OP_W-1:0] OP_SQRT_INI = 5'd7;
    localparam logic [OP_W-1:0] OP_SQRT_STP = 5'd8;
    localparam logic [OP_W-1:0] OP_LEG_WR   = 5'd9;
    localparam logic [OP_W-1:0] OP_SRCH_INI = 5'd10;
    localparam logic [OP_W-1:0] OP_ENTER    = 5'd11;
    localparam logic [OP_W-1:0] OP_CLOSE_RD = 5'd12;
    localparam logic [OP_W-1:0] OP_CLOSE    = 5'd13;
    localparam logic [OP_W-1:0] OP_LOOP     = 5'd14;
    localparam logic [OP_W-1:0] OP_DESC     = 5'd15;
    localparam logic [OP_W-1:0] OP_RET      = 5'd16;
    localparam logic [OP_W-1:0] OP_UNDO     = 5'd17;
    localparam logic [OP_W-1:0] OP_RESULT   = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic n_small;
        logic pair_last;
        logic sqrt_last;
        logic prune;
        logic leaf;
        logic loop_end;
        logic root;
        logic out_busy;
    } t_dp_status;

endpackage

[hw/rtl/bfst_datapath.sv]
// Datapath: city stores, leg table, square-root unit, search stack and result register.
module bfst_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bfst_pkg::t_dp_cmd                 i_cmd,
    input  logic [bfst_pkg::COORD_W-1:0]      i_city_x,
    input  logic [bfst_pkg::COORD_W-1:0]      i_city_y,
    input  logic                              i_res_ready,
    output bfst_pkg::t_dp_status              o_status,
    output logic                              o_res_valid,
    output logic                              o_res_status,
    output logic [bfst_pkg::LEN_W-1:0]        o_res_len,
    output logic [bfst_pkg::CNT_W-1:0]        o_res_cnt
);

    localparam int IW = bfst_pkg::CITY_IDX_W;
    localparam int CW = bfst_pkg::CNT_W;
    localparam int XW = bfst_pkg::COORD_W;
    localparam int QW = bfst_pkg::SQ_W;
    localparam int SW = bfst_pkg::SUM_W;
    localparam int MC = bfst_pkg::MAX_CITY_COUNT;

    function automatic logic [XW-1:0] f_abs_diff(input logic [XW-1:0] a,
                                                 input logic [XW-1:0] b);
        logic [XW:0] d;
        logic [XW:0] m;
        d = {a[XW-1], a} - {b[XW-1], b};
        m = d[XW] ? (~d + 1'b1) : d;
        return m[XW-1:0];
    endfunction

    logic [XW-1:0] x_mem [MC];
    logic [XW-1:0] y_mem [MC];
    logic [bfst_pkg::LEG_W-1:0] leg_mem [1 << bfst_pkg::LEG_ADDR_W];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic [IW-1:0] r_i, r_j;
    logic [XW-1:0] r_xa, r_xb, r_ya, r_yb;
    logic [XW-1:0] r_dx, r_dy;
    logic [2*XW-1:0] r_dx2, r_dy2;
    logic [QW-1:0] r_rem, r_root, r_bit;
    logic [bfst_pkg::STEP_W-1:0] r_k;
    logic [bfst_pkg::LEG_W-1:0] r_leg_q;
    logic [IW-1:0] r_order [MC];
    logic [CW-1:0] r_idx [MC+1];
    logic [SW-1:0] r_part [MC+1];
    logic [CW-1:0] r_lvl;
    logic [SW-1:0] r_best;
    logic r_ov, r_ostat;
    logic [bfst_pkg::LEN_W-1:0] r_olen;
    logic [CW-1:0] r_ocnt;

    logic room;
    logic [CW-1:0] n_count;
    logic [QW-1:0] trial;
    logic [IW-1:0] lvl_ix, prev_ix, last_ix, idx_ix, nm1_i;
    logic [CW-1:0] cur_idx;
    logic [SW-1:0] cur_part, leg_sum;
    logic [bfst_pkg::OP_W-1:0] op;

    assign op       = i_cmd.op;
    assign room     = (r_count < CW'(MC));
    assign n_count  = r_count + CW'(room);
    assign trial    = r_root + r_bit;
    assign lvl_ix   = r_lvl[IW-1:0];
    assign prev_ix  = IW'(r_lvl - 1'b1);
    assign last_ix  = IW'(r_n - 1'b1);
    assign nm1_i    = last_ix;
    assign cur_idx  = r_idx[r_lvl];
    assign idx_ix   = cur_idx[IW-1:0];
    assign cur_part = r_part[r_lvl];
    assign leg_sum  = cur_part + SW'(r_leg_q);

    always_comb begin
        o_status.n_small   = (n_count < CW'(2));
        o_status.pair_last = (r_i == nm1_i) && (r_j == nm1_i);
        o_status.sqrt_last = (r_k == bfst_pkg::STEP_W'(bfst_pkg::SQRT_STEPS - 1));
        o_status.prune     = (cur_part >= r_best);
        o_status.leaf      = (r_lvl == r_n);
        o_status.loop_end  = (cur_idx == r_n);
        o_status.root      = (r_lvl == CW'(1));
        o_status.out_busy  = r_ov && !i_res_ready;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_res_ready) begin
                r_ov <= 1'b0;
            end
            case (op) inside
                bfst_pkg::OP_LOAD: begin
                    r_count <= n_count;
                end
                bfst_pkg::OP_ERR, bfst_pkg::OP_START: begin
                    r_count <= '0;
                    if (op == bfst_pkg::OP_ERR) begin
                        r_ov <= 1'b1;
                    end
                end
                bfst_pkg::OP_RESULT: begin
                    r_ov <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers and memories
    always_ff @(posedge i_clk) begin
        case (op) inside
            bfst_pkg::OP_LOAD, bfst_pkg::OP_ERR, bfst_pkg::OP_START: begin
                if (room) begin
                    x_mem[r_count[IW-1:0]] <= i_city_x;
                    y_mem[r_count[IW-1:0]] <= i_city_y;
                end
                if (op == bfst_pkg::OP_ERR) begin
                    r_ostat <= 1'b1;
                    r_olen  <= '0;
                    r_ocnt  <= n_count;
                end
                if (op == bfst_pkg::OP_START) begin
                    r_n <= n_count;
                    r_i <= '0;
                    r_j <= '0;
                end
            end
            bfst_pkg::OP_PAIR_RD: begin
                r_xa <= x_mem[r_i];
                r_xb <= x_mem[r_j];
                r_ya <= y_mem[r_i];
                r_yb <= y_mem[r_j];
            end
            bfst_pkg::OP_PAIR_DIF: begin
                r_dx <= f_abs_diff(r_xa, r_xb);
                r_dy <= f_abs_diff(r_ya, r_yb);
            end
            bfst_pkg::OP_PAIR_SQ: begin
                r_dx2 <= r_dx * r_dx;
                r_dy2 <= r_dy * r_dy;
            end
            bfst_pkg::OP_SQRT_INI: begin
                r_rem  <= {1'b0, r_dx2} + {1'b0, r_dy2};
                r_root <= '0;
                r_bit  <= QW'(1) << (QW - 1);
                r_k    <= '0;
            end
            bfst_pkg::OP_SQRT_STP: begin
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_k   <= r_k + 1'b1;
            end
            bfst_pkg::OP_LEG_WR: begin
                leg_mem[{r_i, r_j}] <= r_root[bfst_pkg::LEG_W-1:0];
                if (r_j == nm1_i) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            bfst_pkg::OP_SRCH_INI: begin
                for (int k = 0; k < MC; k++) begin
                    r_order[k] <= IW'(k);
                end
                r_lvl     <= CW'(1);
                r_part[1] <= '0;
                r_best    <= '1;
            end
            bfst_pkg::OP_ENTER: begin
                r_idx[r_lvl] <= r_lvl;
            end
            bfst_pkg::OP_CLOSE_RD: begin
                r_leg_q <= leg_mem[{r_order[last_ix], r_order[0]}];
            end
            bfst_pkg::OP_CLOSE: begin
                if (leg_sum < r_best) begin
                    r_best <= leg_sum;
                end
            end
            bfst_pkg::OP_LOOP, bfst_pkg::OP_UNDO: begin
                // swap the chosen city into this level; a self-swap writes once
                r_order[lvl_ix] <= r_order[idx_ix];
                if (idx_ix != lvl_ix) begin
                    r_order[idx_ix] <= r_order[lvl_ix];
                end
                if (op == bfst_pkg::OP_LOOP) begin
                    r_leg_q <= leg_mem[{r_order[prev_ix], r_order[idx_ix]}];
                end else begin
                    r_idx[r_lvl] <= cur_idx + 1'b1;
                end
            end
            bfst_pkg::OP_DESC: begin
                r_part[r_lvl + 1'b1] <= leg_sum;
                r_lvl                <= r_lvl + 1'b1;
            end
            bfst_pkg::OP_RET: begin
                r_lvl <= r_lvl - 1'b1;
            end
            bfst_pkg::OP_RESULT: begin
                r_ostat <= 1'b0;
                r_olen  <= (r_best > SW'({bfst_pkg::LEN_W{1'b1}})) ?
                           '1 : r_best[bfst_pkg::LEN_W-1:0];
                r_ocnt  <= r_n;
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid  = r_ov;
    assign o_res_status = r_ostat;
    assign o_res_len    = r_olen;
    assign o_res_cnt    = r_ocnt;

endmodule

[hw/rtl/bfst_ctrl.sv]
// Controller: sequences loading, leg table build and the depth-first tour search.
module bfst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_fire,
    input  logic                 i_in_last,
    input  bfst_pkg::t_dp_status i_status,
    output bfst_pkg::t_dp_cmd    o_cmd,
    output logic                 o_idle
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PRD   = 4'd1;
    localparam logic [3:0] ST_PDIF  = 4'd2;
    localparam logic [3:0] ST_PSQ   = 4'd3;
    localparam logic [3:0] ST_SQI   = 4'd4;
    localparam logic [3:0] ST_SQS   = 4'd5;
    localparam logic [3:0] ST_LWR   = 4'd6;
    localparam logic [3:0] ST_SINIT = 4'd7;
    localparam logic [3:0] ST_ENTER = 4'd8;
    localparam logic [3:0] ST_CLOSE = 4'd9;
    localparam logic [3:0] ST_LOOP  = 4'd10;
    localparam logic [3:0] ST_DESC  = 4'd11;
    localparam logic [3:0] ST_RET   = 4'd12;
    localparam logic [3:0] ST_UNDO  = 4'd13;
    localparam logic [3:0] ST_DONE  = 4'd14;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = bfst_pkg::OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    if (!i_in_last) begin
                        o_cmd.op = bfst_pkg::OP_LOAD;
                    end else if (i_status.n_small) begin
                        o_cmd.op = bfst_pkg::OP_ERR;
                    end else begin
                        o_cmd.op = bfst_pkg::OP_START;
                        n_state  = ST_PRD;
                    end
                end
            end
            ST_PRD: begin
                o_cmd.op = bfst_pkg::OP_PAIR_RD;
                n_state  = ST_PDIF;
            end
            ST_PDIF: begin
                o_cmd.op = bfst_pkg::OP_PAIR_DIF;
                n_state  = ST_PSQ;
            end
            ST_PSQ: begin
                o_cmd.op = bfst_pkg::OP_PAIR_SQ;
                n_state  = ST_SQI;
            end
            ST_SQI: begin
                o_cmd.op = bfst_pkg::OP_SQRT_INI;
                n_state  = ST_SQS;
            end
            ST_SQS: begin
                o_cmd.op = bfst_pkg::OP_SQRT_STP;
                if (i_status.sqrt_last) begin
                    n_state = ST_LWR;
                end
            end
            ST_LWR: begin
                o_cmd.op = bfst_pkg::OP_LEG_WR;
                n_state  = i_status.pair_last ? ST_SINIT : ST_PRD;
            end
            ST_SINIT: begin
                o_cmd.op = bfst_pkg::OP_SRCH_INI;
                n_state  = ST_ENTER;
            end
            ST_ENTER: begin
                if (i_status.prune) begin
                    n_state = ST_RET;
                end else if (i_status.leaf) begin
                    o_cmd.op = bfst_pkg::OP_CLOSE_RD;
                    n_state  = ST_CLOSE;
                end else begin
                    o_cmd.op = bfst_pkg::OP_ENTER;
                    n_state  = ST_LOOP;
                end
            end
            ST_CLOSE: begin
                o_cmd.op = bfst_pkg::OP_CLOSE;
                n_state  = ST_RET;
            end
            ST_LOOP: begin
                if (i_status.loop_end) begin
                    n_state = ST_RET;
                end else begin
                    o_cmd.op = bfst_pkg::OP_LOOP;
                    n_state  = ST_DESC;
                end
            end
            ST_DESC: begin
                o_cmd.op = bfst_pkg::OP_DESC;
                n_state  = ST_ENTER;
            end
            ST_RET: begin
                if (i_status.root) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.op = bfst_pkg::OP_RET;
                    n_state  = ST_UNDO;
                end
            end
            ST_UNDO: begin
                o_cmd.op = bfst_pkg::OP_UNDO;
                n_state  = ST_LOOP;
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = bfst_pkg::OP_RESULT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

[hw/rtl/brute_force_shortest_tour_top.sv]
// Sequence: a city transfer is stored while the store has room; a last city with fewer than two
// cities shows its result the next cycle. Otherwise the leg table is built over n*n city pairs,
// each through pair read, difference, square, square-root init, bit-serial square-root steps and
// leg write; then the search is set up, runs depth first, and the result is posted.
// Throughput: one city per cycle while loading; input holds off during a search or result stall.
// Reset: synchronous, active low; clears control state and the city count, stores stay undefined.
module brute_force_shortest_tour_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [19:0] city_x, [39:20] city_y
    input  logic        s_axis_tlast,  // last_city
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [23:0] shortest_length, [27:24] cities_used, zero pad
    output logic        m_axis_tuser   // status
);

    bfst_pkg::t_dp_cmd    cmd;
    bfst_pkg::t_dp_status status;
    logic                 idle;
    logic                 in_fire;
    logic                 res_status;
    logic [bfst_pkg::LEN_W-1:0] res_len;
    logic [bfst_pkg::CNT_W-1:0] res_cnt;

    // Take cities only between searches, and only while the result register can
    // accept a result that a last city may produce right away.
    assign s_axis_tready = idle && !status.out_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    bfst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_in_last (s_axis_tlast),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_idle    (idle)
    );

    bfst_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_city_x     (s_axis_tdata[19:0]),
        .i_city_y     (s_axis_tdata[39:20]),
        .i_res_ready  (m_axis_tready),
        .o_status     (status),
        .o_res_valid  (m_axis_tvalid),
        .o_res_status (res_status),
        .o_res_len    (res_len),
        .o_res_cnt    (res_cnt)
    );

    // Pack the result transfer: length low, city count above, pad to a byte.
    assign m_axis_tdata = {4'b0000, res_cnt, res_len};
    assign m_axis_tuser = res_status;

endmodule

[hw/rtl/bfst_checker.sv]
// Port-level checker of the shortest-tour block and its bind.
`include "brute_force_shortest_tour_top_assert.svh"

module bfst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `BFST_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `BFST_ASSERT_NOW(a_err_fields, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[23:0] == 24'd0) && (m_axis_tdata[27:24] < 4'd2))
    `BFST_ASSERT_NOW(a_ok_count, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[27:24] >= 4'd2) && (m_axis_tdata[27:24] <= 4'(bfst_pkg::MAX_CITY_COUNT)) && (m_axis_tdata[31:28] == 4'd0))
    `BFST_ASSERT_NXT(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid || !s_axis_tready)

endmodule

bind brute_force_shortest_tour_top bfst_checker u_bfst_checker (.*);

[verif/brute_force_shortest_tour_top_tb.sv]
// Self-checking testbench for the exhaustive shortest closed tour block.
module brute_force_shortest_tour_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF   = 10;
    localparam int  CITY_GOAL  = 1000;
    localparam int  CALM_AFTER = 850;
    localparam int  DRAIN_AT   = 500;
    localparam int  SETTLE     = 100;
    localparam longint CYCLE_LIMIT = 10_000_000;

    // One tour report as the block sends it.
    typedef struct packed {
        logic                       status;
        logic [bfst_pkg::LEN_W-1:0] length;
        logic [3:0]                 used;
    } t_tour_report;

    // Collects the cities of the current set, works out the shortest tour when the
    // set closes and compares reported tours against that prediction.
    class tour_scoreboard;
        int             set_x[$];
        int             set_y[$];
        t_tour_report   reports_due[$];
        longint unsigned leg[bfst_pkg::MAX_CITY_COUNT][bfst_pkg::MAX_CITY_COUNT];
        int             order[bfst_pkg::MAX_CITY_COUNT];
        longint unsigned best;
        int             mismatches;

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Branch and bound over orderings; the first city stays fixed.
        function void walk(int level, int n, longint unsigned partial);
            longint unsigned total;
            int t;
            if (partial >= best) return;
            if (level == n) begin
                total = partial + leg[order[n-1]][order[0]];
                if (total < best) best = total;
                return;
            end
            for (int i = level; i < n; i++) begin
                t = order[level]; order[level] = order[i]; order[i] = t;
                walk(level + 1, n, partial + leg[order[level-1]][order[level]]);
                t = order[level]; order[level] = order[i]; order[i] = t;
            end
        endfunction

        function void note_city(logic signed [bfst_pkg::COORD_W-1:0] x,
                                logic signed [bfst_pkg::COORD_W-1:0] y,
                                logic last);
            t_tour_report rep;
            longint dx;
            longint dy;
            int n;
            // A full store drops the city but a last flag still closes the set.
            if (set_x.size() < bfst_pkg::MAX_CITY_COUNT) begin
                set_x.push_back(int'(x));
                set_y.push_back(int'(y));
            end
            if (!last) return;
            n = set_x.size();
            rep.used = n[3:0];
            if (n < 2) begin
                rep.status = 1'b1;
                rep.length = '0;
            end else begin
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        dx = longint'(set_x[i]) - longint'(set_x[j]);
                        dy = longint'(set_y[i]) - longint'(set_y[j]);
                        leg[i][j] = root_floor(longint'(dx * dx + dy * dy));
                    end
                    order[i] = i;
                end
                best = 64'hFFFF_FFFF_FFFF_FFFF;
                walk(1, n, 0);
                rep.status = 1'b0;
                rep.length = (best > 64'hFF_FFFF) ? {bfst_pkg::LEN_W{1'b1}} :
                             best[bfst_pkg::LEN_W-1:0];
            end
            reports_due.push_back(rep);
            set_x.delete();
            set_y.delete();
        endfunction

        function void check_report(t_tour_report got);
            t_tour_report want;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: status %0d length %0d used %0d",
                             got.status, got.length, got.used);
                return;
            end
            want = reports_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report mismatch (status/length/used): expected %0d/%0d/%0d",
                             want.status, want.length, want.used,
                             ", got %0d/%0d/%0d", got.status, got.length, got.used);
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [19:0] city_x, [39:20] city_y
    logic        s_axis_tlast = 1'b0; // last_city
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [23:0] shortest_length, [27:24] cities_used
    logic        m_axis_tuser;        // status

    tour_scoreboard tours = new();
    int     cities_sent;
    bit     calm;
    longint cycles = 0;

    brute_force_shortest_tour_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check every transfer, stall tready in random bursts.
    initial begin
        int stall_left;
        t_tour_report got;
        stall_left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.length = m_axis_tdata[23:0];
                got.used   = m_axis_tdata[27:24];
                tours.check_report(got);
            end
            if (calm) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 9) < 2) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Drive one city and hold it until the transfer; maybe idle first.
    task automatic send_city(logic signed [19:0] x, logic signed [19:0] y, logic last);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        tours.note_city(x, y, last);
        cities_sent++;
    endtask

    // Drop valid and hold the sender until every predicted tour has come back.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tours.pending() != 0);
    endtask

    function automatic logic [19:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 20'h80000;
            1:       return 20'h7FFFF;
            default: return 20'($urandom());
        endcase
    endfunction

    // A set of n cities with random positions.
    task automatic send_scatter(int n);
        for (int i = 0; i < n; i++)
            send_city(pick_coord(), pick_coord(), i == n - 1);
    endtask

    // A full store: the first cities share one point, which keeps the search short,
    // and anything past the capacity is dropped.
    task automatic send_crowd(int n, logic [19:0] px, logic [19:0] py);
        for (int i = 0; i < n; i++) begin
            if (i < bfst_pkg::MAX_CITY_COUNT)
                send_city(px, py, i == n - 1);
            else
                send_city(pick_coord(), pick_coord(), i == n - 1);
        end
    endtask

    initial begin
        int kind;
        bit drained;
        cities_sent = 0;
        calm = 1'b0;
        drained = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single cities at the corners: too few for a tour.
        send_city(20'h80000, 20'h7FFFF, 1'b1);
        send_city(20'h7FFFF, 20'h80000, 1'b1);
        // Two cities at opposite corners: the longest possible legs.
        send_city(20'h80000, 20'h80000, 1'b0);
        send_city(20'h7FFFF, 20'h7FFFF, 1'b1);
        // Two cities on one point: zero length.
        send_city(20'h00100, 20'hFFF00, 1'b0);
        send_city(20'h00100, 20'hFFF00, 1'b1);
        // Three cities: every ordering is a tie.
        send_scatter(3);
        // Overfull store, last flag on a dropped city.
        send_crowd(13, 20'h12345, 20'hEDCBA);
        drain_reports();

        while (cities_sent < CITY_GOAL) begin
            if (cities_sent > CALM_AFTER) calm = 1'b1;
            if (!drained && cities_sent > DRAIN_AT) begin
                drain_reports();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 8)
                send_crowd($urandom_range(11, 14), pick_coord(), pick_coord());
            else if (kind < 15)
                send_scatter(1);
            else if (kind < 16)
                send_scatter(8);
            else if (kind < 26)
                send_scatter(7);
            else
                send_scatter($urandom_range(2, 6));
        end

        drain_reports();
        repeat (SETTLE) @(posedge i_clk);
        if (tours.mismatches == 0 && tours.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bfst_pkg.sv
hw/rtl/bfst_datapath.sv
hw/rtl/bfst_ctrl.sv
hw/rtl/brute_force_shortest_tour_top.sv
hw/rtl/bfst_checker.sv
verif/brute_force_shortest_tour_top_tb.sv
